[hw/rtl/itoa_pkg.sv]
// Shared types and constants for the integer to decimal text converter.
package itoa_pkg;

    localparam int unsigned C_VALUE_BITS = 32;
    localparam int unsigned C_NUM_DIGITS = 10;
    localparam int unsigned C_CHAR_BITS  = 6;

    localparam logic [C_CHAR_BITS-1:0] C_ASCII_ZERO  = 6'd48;
    localparam logic [C_CHAR_BITS-1:0] C_ASCII_MINUS = 6'd45;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic clear;
        logic convert;
        logic unload;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

endpackage

[hw/rtl/itoa_cell.sv]
// One decimal digit cell of the shift-and-add-3 chain.
module itoa_cell (
    input  logic                  i_clk,
    input  itoa_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_bit,
    input  itoa_pkg::t_digit      i_digit,
    output logic                  o_bit,
    output itoa_pkg::t_digit      o_digit
);

    itoa_pkg::t_digit r_digit;
    itoa_pkg::t_digit n_digit;
    itoa_pkg::t_digit w_adj;

    always_comb begin
        w_adj = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    end

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.convert) begin
            n_digit = {w_adj[2:0], i_bit};
        end else if (i_ctrl.unload) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_bit   = w_adj[3];
    assign o_digit = r_digit;

endmodule

[hw/rtl/itoa_ctrl.sv]
// Sequencer: magnitude shift register, bit and digit counters, result beats.
module itoa_ctrl (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [itoa_pkg::C_VALUE_BITS-1:0]       i_value,
    input  itoa_pkg::t_digit                        i_top_digit,
    output logic                                    o_busy,
    output logic                                    o_serial_bit,
    output itoa_pkg::t_cell_ctrl                    o_cell_ctrl,
    output logic                                    o_strobe,
    output logic [itoa_pkg::C_CHAR_BITS-1:0]        o_character,
    output logic                                    o_last
);

    itoa_pkg::t_state                       r_state;
    itoa_pkg::t_state                       n_state;
    logic [itoa_pkg::C_VALUE_BITS-1:0]      r_mag;
    logic [itoa_pkg::C_VALUE_BITS-1:0]      n_mag;
    logic                                   r_neg;
    logic                                   n_neg;
    logic [4:0]                             r_cnt;
    logic [4:0]                             n_cnt;
    logic [3:0]                             r_left;
    logic [3:0]                             n_left;
    logic                                   w_accept;
    logic                                   w_skip;

    assign w_accept = i_start && (r_state == itoa_pkg::ST_IDLE);
    assign w_skip   = (i_top_digit == 4'd0) && (r_left > 4'd1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itoa_pkg::ST_IDLE: begin
                if (i_start) n_state = itoa_pkg::ST_CONV;
            end
            itoa_pkg::ST_CONV: begin
                if (r_cnt == 5'd31) n_state = itoa_pkg::ST_SKIP;
            end
            itoa_pkg::ST_SKIP: begin
                if (!w_skip) n_state = itoa_pkg::ST_EMIT;
            end
            itoa_pkg::ST_EMIT: begin
                if (r_left == 4'd1) n_state = itoa_pkg::ST_IDLE;
            end
            default: n_state = itoa_pkg::ST_IDLE;
        endcase
    end

    // datapath registers next values
    always_comb begin
        n_mag  = r_mag;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_left = r_left;
        if (w_accept) begin
            n_neg = i_value[itoa_pkg::C_VALUE_BITS-1];
            n_mag = i_value[itoa_pkg::C_VALUE_BITS-1] ? ('0 - i_value) : i_value;
            n_cnt = '0;
        end
        if (r_state == itoa_pkg::ST_CONV) begin
            n_mag  = {r_mag[itoa_pkg::C_VALUE_BITS-2:0], 1'b0};
            n_cnt  = r_cnt + 5'd1;
            n_left = 4'(itoa_pkg::C_NUM_DIGITS);
        end
        if ((r_state == itoa_pkg::ST_SKIP && w_skip) || r_state == itoa_pkg::ST_EMIT) begin
            n_left = r_left - 4'd1;
        end
    end

    // outputs
    always_comb begin
        o_busy               = (r_state != itoa_pkg::ST_IDLE);
        o_serial_bit         = r_mag[itoa_pkg::C_VALUE_BITS-1];
        o_cell_ctrl.clear    = w_accept;
        o_cell_ctrl.convert  = 1'b0;
        o_cell_ctrl.unload   = 1'b0;
        o_strobe             = 1'b0;
        o_character          = itoa_pkg::C_ASCII_ZERO + {2'b00, i_top_digit};
        o_last               = 1'b0;
        unique case (r_state)
            itoa_pkg::ST_IDLE: begin
            end
            itoa_pkg::ST_CONV: begin
                o_cell_ctrl.convert = 1'b1;
                if (r_cnt == 5'd0 && r_neg) begin
                    o_strobe    = 1'b1;
                    o_character = itoa_pkg::C_ASCII_MINUS;
                end
            end
            itoa_pkg::ST_SKIP: begin
                o_cell_ctrl.unload = w_skip;
            end
            itoa_pkg::ST_EMIT: begin
                o_cell_ctrl.unload = 1'b1;
                o_strobe           = 1'b1;
                o_last             = (r_left == 4'd1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_neg <= n_neg;
    end

endmodule

[hw/rtl/int_to_decimal_ascii.sv]
// Signed 32-bit integer to decimal ASCII text, one character per beat.
// An item is taken when start is high and busy is low. The magnitude is fed
// one bit per cycle into a row of ten BCD digit cells (shift-and-add-3); a
// minus sign, if any, leaves as the first bit is fed in. The digit row
// then shifts toward the top cell: leading zeros are dropped, then one
// digit leaves per cycle, o_last marking the final one. Each character is
// valid for exactly one cycle while o_strobe is high; the receiver cannot
// stall, so it must take every beat as it comes.
module int_to_decimal_ascii (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [31:0]                  i_value,
    output logic                                o_strobe,
    output logic [5:0]                          o_character,
    output logic                                o_last
);

    itoa_pkg::t_cell_ctrl   w_cell_ctrl;
    logic                   w_serial_bit;
    logic                   w_bit   [itoa_pkg::C_NUM_DIGITS];
    itoa_pkg::t_digit       w_digit [itoa_pkg::C_NUM_DIGITS];

    itoa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_value      (i_value),
        .i_top_digit  (w_digit[itoa_pkg::C_NUM_DIGITS-1]),
        .o_busy       (busy),
        .o_serial_bit (w_serial_bit),
        .o_cell_ctrl  (w_cell_ctrl),
        .o_strobe     (o_strobe),
        .o_character  (o_character),
        .o_last       (o_last)
    );

    for (genvar g = 0; g < itoa_pkg::C_NUM_DIGITS; g++) begin : g_cell
        if (g == 0) begin : g_first
            itoa_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_cell_ctrl),
                .i_bit   (w_serial_bit),
                .i_digit (4'd0),
                .o_bit   (w_bit[g]),
                .o_digit (w_digit[g])
            );
        end else begin : g_rest
            itoa_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_cell_ctrl),
                .i_bit   (w_bit[g-1]),
                .i_digit (w_digit[g-1]),
                .o_bit   (w_bit[g]),
                .o_digit (w_digit[g])
            );
        end
    end

endmodule
